// File: rtl/somr_pkg.sv
// shared types and constants for the spiral order matrix reader
package somr_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 4;
    localparam int LOAD_W = 7;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } t_dir;

endpackage

// File: rtl/somr_ram.sv
// generic single write port ram with registered read
module somr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/spiral_order_matrix_reader_core.sv
// top level: loads a matrix row by row and plays it back in clockwise spiral order
//
// Usage: each start transfer accepted while busy is low stores one element, in
// row-major order; busy stays low while the matrix fills. The transfer that
// completes the matrix (row_count * column_count elements, with zero counts read
// as 1 and counts above MAX_DIM read as MAX_DIM) raises busy for the walk, in
// which one element is read from the element store per cycle. Results appear in
// the cycle after their read, one per cycle with o_out_strobe high, back to back,
// and the final one carries o_out_last. The receiver cannot stall: every result
// is on the ports for exactly one cycle. busy falls in the cycle the last result
// shows, so the next load may start right then. The store's single read port sets
// the playback rate at one result per cycle. Registers sit on an APB-style port
// at byte addresses 0 (row_count) and 4 (column_count); the user must write them
// only while the block is idle, which the block itself does not enforce.
module spiral_order_matrix_reader_core #(
    parameter int MAX_DIM = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // element load
    input  logic                                start,
    output logic                                busy,
    input  logic signed [somr_pkg::DATA_W-1:0]  i_element_value,
    // spiral results
    output logic                                o_out_strobe,
    output logic signed [somr_pkg::DATA_W-1:0]  o_out_value,
    output logic                                o_out_last
);

    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int CW     = somr_pkg::CFG_W;
    localparam int LW     = somr_pkg::LOAD_W;

    // config registers
    logic [CW-1:0] r_row_count;
    logic [CW-1:0] r_column_count;

    // control
    somr_pkg::t_state r_state, n_state;
    logic [LW-1:0]    r_load, n_load;

    // walk position, bounds and emitted count
    somr_pkg::t_dir   r_dir, n_dir;
    logic [DIM_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_top, n_top;
    logic [DIM_W-1:0] r_bottom, n_bottom;
    logic [DIM_W-1:0] r_left, n_left;
    logic [DIM_W-1:0] r_right, n_right;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [LW-1:0]    r_cnt, n_cnt;

    // read pipeline
    logic r_rd_vld;
    logic r_rd_last;

    logic [CW-1:0]     eff_rows;
    logic [CW-1:0]     eff_cols;
    logic [LW-1:0]     total;
    logic [LW-1:0]     load_inc;
    logic              load_done;
    logic              accept;
    logic              walk_last;
    logic              cfg_write;
    logic [ADDR_W-1:0] addr_delta;
    logic [ADDR_W-1:0] cols_a;
    logic              ram_we;
    logic [somr_pkg::DATA_W-1:0] ram_rdata;

    // ------------------------------------------------------------------
    // config port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= somr_pkg::DIM_RESET;
            r_column_count <= somr_pkg::DIM_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                somr_pkg::REG_ROW_COUNT:    r_row_count    <= pwdata[CW-1:0];
                somr_pkg::REG_COLUMN_COUNT: r_column_count <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            somr_pkg::REG_ROW_COUNT:    prdata[CW-1:0] = r_row_count;
            somr_pkg::REG_COLUMN_COUNT: prdata[CW-1:0] = r_column_count;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // effective matrix size: zero means one, above MAX_DIM saturates
    // ------------------------------------------------------------------
    always_comb begin
        priority if (r_row_count == '0) eff_rows = CW'(1);
        else if (r_row_count > CW'(MAX_DIM)) eff_rows = CW'(MAX_DIM);
        else eff_rows = r_row_count;

        priority if (r_column_count == '0) eff_cols = CW'(1);
        else if (r_column_count > CW'(MAX_DIM)) eff_cols = CW'(MAX_DIM);
        else eff_cols = r_column_count;
    end

    assign total  = {{(LW-CW){1'b0}}, eff_rows} * {{(LW-CW){1'b0}}, eff_cols};
    assign cols_a = ADDR_W'(eff_cols);

    // ------------------------------------------------------------------
    // load side
    // ------------------------------------------------------------------
    assign accept    = start & ~busy;
    assign load_inc  = r_load + LW'(1);
    assign load_done = (load_inc >= total);
    assign walk_last = (r_cnt == total - LW'(1));

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            somr_pkg::ST_IDLE: begin
                if (accept && load_done) n_state = somr_pkg::ST_WALK;
            end
            somr_pkg::ST_WALK: begin
                if (walk_last) n_state = somr_pkg::ST_IDLE;
            end
            default: n_state = somr_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb begin
        busy   = 1'b0;
        ram_we = 1'b0;
        unique case (r_state)
            somr_pkg::ST_IDLE: ram_we = start;
            somr_pkg::ST_WALK: busy   = 1'b1;
            default: ;
        endcase
    end

    // load count: wraps to zero once the matrix is complete
    always_comb begin
        n_load = r_load;
        if (accept) n_load = load_done ? '0 : load_inc;
    end

    // ------------------------------------------------------------------
    // walk step: one shared address adder, turn at each bound
    // ------------------------------------------------------------------
    always_comb begin
        n_dir      = r_dir;
        n_row      = r_row;
        n_col      = r_col;
        n_top      = r_top;
        n_bottom   = r_bottom;
        n_left     = r_left;
        n_right    = r_right;
        n_cnt      = r_cnt + LW'(1);
        addr_delta = ADDR_W'(1);

        unique case (r_dir)
            somr_pkg::DIR_RIGHT: begin
                if (r_col != r_right) begin
                    n_col      = r_col + DIM_W'(1);
                    addr_delta = ADDR_W'(1);
                end else begin
                    // top row done, go down the right column
                    n_top      = r_top + DIM_W'(1);
                    n_row      = r_row + DIM_W'(1);
                    addr_delta = cols_a;
                    n_dir      = somr_pkg::DIR_DOWN;
                end
            end
            somr_pkg::DIR_DOWN: begin
                if (r_row != r_bottom) begin
                    n_row      = r_row + DIM_W'(1);
                    addr_delta = cols_a;
                end else begin
                    n_right    = r_right - DIM_W'(1);
                    n_col      = r_col - DIM_W'(1);
                    addr_delta = '1;
                    n_dir      = somr_pkg::DIR_LEFT;
                end
            end
            somr_pkg::DIR_LEFT: begin
                if (r_col != r_left) begin
                    n_col      = r_col - DIM_W'(1);
                    addr_delta = '1;
                end else begin
                    n_bottom   = r_bottom - DIM_W'(1);
                    n_row      = r_row - DIM_W'(1);
                    addr_delta = -cols_a;
                    n_dir      = somr_pkg::DIR_UP;
                end
            end
            somr_pkg::DIR_UP: begin
                if (r_row != r_top) begin
                    n_row      = r_row - DIM_W'(1);
                    addr_delta = -cols_a;
                end else begin
                    // ring closed, step inward along the next top row
                    n_left     = r_left + DIM_W'(1);
                    n_col      = r_col + DIM_W'(1);
                    addr_delta = ADDR_W'(1);
                    n_dir      = somr_pkg::DIR_RIGHT;
                end
            end
            default: ;
        endcase

        n_addr = r_addr + addr_delta;

        // start of a new spiral: full bounds, top left corner
        if (r_state == somr_pkg::ST_IDLE) begin
            n_dir    = somr_pkg::DIR_RIGHT;
            n_row    = '0;
            n_col    = '0;
            n_top    = '0;
            n_left   = '0;
            n_bottom = DIM_W'(eff_rows - CW'(1));
            n_right  = DIM_W'(eff_cols - CW'(1));
            n_addr   = '0;
            n_cnt    = '0;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= somr_pkg::ST_IDLE;
            r_load   <= '0;
            r_rd_vld <= 1'b0;
            r_dir    <= somr_pkg::DIR_RIGHT;
        end else begin
            r_state  <= n_state;
            r_load   <= n_load;
            r_rd_vld <= (r_state == somr_pkg::ST_WALK);
            r_dir    <= n_dir;
        end
    end

    // walk payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_col     <= n_col;
        r_top     <= n_top;
        r_bottom  <= n_bottom;
        r_left    <= n_left;
        r_right   <= n_right;
        r_addr    <= n_addr;
        r_cnt     <= n_cnt;
        r_rd_last <= walk_last;
    end

    // ------------------------------------------------------------------
    // element store: written on load, read once per walk cycle
    // ------------------------------------------------------------------
    somr_ram #(
        .WIDTH (somr_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_load[ADDR_W-1:0]),
        .i_wdata (i_element_value),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // each result transfer shows in the cycle after its read
    assign o_out_strobe = r_rd_vld;
    assign o_out_value  = ram_rdata;
    assign o_out_last   = r_rd_vld & r_rd_last;

endmodule

// File: verif/spiral_order_matrix_reader_core_tb.sv
`timescale 1ns / 1ps
// testbench for the spiral order matrix reader: directed and random loads checked by a predictor
module spiral_order_matrix_reader_core_tb;

    localparam int CLK_HALF      = 6;
    localparam int DIM_MAX       = 8;
    localparam int STORE_DEPTH   = 64;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);
    localparam int SETTLE_CYCLES = 4;   // results lag their read
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 10;
    localparam int DATA_W        = somr_pkg::DATA_W;
    localparam int CFG_W         = somr_pkg::CFG_W;
    localparam int LOAD_W        = somr_pkg::LOAD_W;

    // one expected word of the spiral playback
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_spiral_word;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       start;
    logic                       busy;
    logic signed [DATA_W-1:0]   i_element_value;
    logic                       o_out_strobe;
    logic signed [DATA_W-1:0]   o_out_value;
    logic                       o_out_last;

    // predictor state: its own copy of the element store, fill counter and size registers
    logic [DATA_W-1:0]  matrix_store [STORE_DEPTH];
    logic [LOAD_W-1:0]  fill_count;
    logic [CFG_W-1:0]   rows_reg;
    logic [CFG_W-1:0]   cols_reg;
    t_spiral_word       spiral_expect_q [$];

    int idle_pct        = 0;
    int mismatches      = 0;
    int loads_accepted  = 0;
    int words_checked   = 0;
    int matrices_played = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    spiral_order_matrix_reader_core #(
        .MAX_DIM(DIM_MAX)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .i_element_value (i_element_value),
        .o_out_strobe    (o_out_strobe),
        .o_out_value     (o_out_value),
        .o_out_last      (o_out_last)
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // zero counts act as one row or column, counts past the maximum saturate
    function automatic int clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_MAX) return DIM_MAX;
        return int'(v);
    endfunction

    // store one element; when the matrix is complete, queue its clockwise spiral
    function automatic void predict_load(input logic [DATA_W-1:0] v);
        int rows;
        int cols;
        int total;
        int top;
        int bottom;
        int left;
        int right;
        int r;
        int c;
        int walk [$];
        t_spiral_word exp_word;
        rows  = clamp_dim(rows_reg);
        cols  = clamp_dim(cols_reg);
        total = rows * cols;
        matrix_store[fill_count[STORE_AW-1:0]] = v;
        fill_count = fill_count + 1'b1;   // 7-bit counter, wraps on its own
        if (int'(fill_count) < total) return;
        fill_count = '0;

        top    = 0;
        bottom = rows - 1;
        left   = 0;
        right  = cols - 1;
        while (top <= bottom && left <= right) begin
            // top row, left to right
            for (c = left; c <= right; c++) walk.insert(walk.size(), top * cols + c);
            top++;
            // right column, downward
            for (r = top; r <= bottom; r++) walk.insert(walk.size(), r * cols + right);
            right--;
            // bottom row, right to left, skipped once the rows are used up
            if (top <= bottom) begin
                for (c = right; c >= left; c--) walk.insert(walk.size(), bottom * cols + c);
                bottom--;
            end
            // left column, upward, skipped once the columns are used up
            if (left <= right) begin
                for (r = bottom; r >= top; r--) walk.insert(walk.size(), r * cols + left);
                left++;
            end
        end
        foreach (walk[k]) begin
            exp_word.value = matrix_store[STORE_AW'(walk[k])];
            exp_word.last  = (k == walk.size() - 1);
            spiral_expect_q.insert(spiral_expect_q.size(), exp_word);
        end
        matrices_played++;
    endfunction

    function automatic void flag_mismatch(input string what, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected %h, got %h", $time, what, exp_v, act_v);
    endfunction

    // ------------------------------------------------------------------
    // result check: every strobed word is compared with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_spiral_word want;
        if (i_rst_n && o_out_strobe) begin
            if (spiral_expect_q.size() == 0) begin
                flag_mismatch("spiral word with nothing pending", '0, o_out_value);
            end else begin
                want = spiral_expect_q.pop_front();
                words_checked++;
                if (o_out_value !== want.value)
                    flag_mismatch("out_value", want.value, o_out_value);
                if (o_out_last !== want.last)
                    flag_mismatch("out_last", {31'd0, want.last}, {31'd0, o_out_last});
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // register write: setup cycle, then access cycle until pready
    task automatic apb_write(input logic reg_idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // register takes the low nibble at this edge
        if (reg_idx == somr_pkg::REG_ROW_COUNT) rows_reg = data[CFG_W-1:0];
        else cols_reg = data[CFG_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input logic reg_idx, input logic [CFG_W-1:0] exp_v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(32-CFG_W){1'b0}}, exp_v})
            flag_mismatch(reg_idx == somr_pkg::REG_ROW_COUNT ? "row_count readback"
                                                             : "column_count readback",
                          {{(32-CFG_W){1'b0}}, exp_v}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write both size registers and read them back
    task automatic set_dims(input logic [31:0] row_word, input logic [31:0] col_word);
        apb_write(somr_pkg::REG_ROW_COUNT, row_word);
        apb_write(somr_pkg::REG_COLUMN_COUNT, col_word);
        apb_read_check(somr_pkg::REG_ROW_COUNT, rows_reg);
        apb_read_check(somr_pkg::REG_COLUMN_COUNT, cols_reg);
    endtask

    function automatic logic [DATA_W-1:0] rand_element();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // one load transfer, with random sender idling ahead of it
    task automatic send_element(input logic [DATA_W-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (busy);
        predict_load(v);
        loads_accepted++;
    endtask

    // keep loading until the predictor sees a spiral go out
    task automatic finish_matrix();
        do send_element(rand_element()); while (fill_count != '0);
    endtask

    // block idle: nothing pending, busy low, then a short settle before any register write
    task automatic wait_playback_done();
        start <= 1'b0;
        @(posedge i_clk);
        while (spiral_expect_q.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly small sizes; some zero, full and oversized counts; junk in the upper bits
    function automatic logic [31:0] pick_dim_word();
        logic [31:0] w;
        int          roll;
        w    = $urandom();
        roll = $urandom_range(99);
        if (roll < 6)       w[CFG_W-1:0] = CFG_W'($urandom_range(9, 15));
        else if (roll < 12) w[CFG_W-1:0] = '0;
        else if (roll < 16) w[CFG_W-1:0] = CFG_W'(DIM_MAX);
        else                w[CFG_W-1:0] = CFG_W'($urandom_range(1, 4));
        return w;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_reset_defaults();
        apb_read_check(somr_pkg::REG_ROW_COUNT, somr_pkg::DIM_RESET);
        apb_read_check(somr_pkg::REG_COLUMN_COUNT, somr_pkg::DIM_RESET);
    endtask

    // 1x1 matrices carry the field extremes, each word is also the last
    task automatic test_single_element();
        set_dims(32'd1, 32'd1);
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);
        send_element(32'h0000_0000);
        send_element(32'hffff_ffff);
        wait_playback_done();
    endtask

    // zero counts with set upper bits behave as a 1x1 matrix
    task automatic test_zero_dimension();
        set_dims(32'hffff_fff0, 32'ha5a5_a5a0);
        finish_matrix();
        wait_playback_done();
    endtask

    // single row, single column and a square that closes after one ring
    task automatic test_strips();
        set_dims(32'd1, 32'd3);
        finish_matrix();
        wait_playback_done();
        set_dims(32'd3, 32'd1);
        finish_matrix();
        wait_playback_done();
        set_dims(32'd2, 32'd2);
        finish_matrix();
        wait_playback_done();
    endtask

    // oversized counts give 8x8; shrink mid-load so the next load plays a 2x3 spiral
    task automatic test_oversize_resize();
        set_dims(32'd15, 32'd9);
        repeat (6) send_element(rand_element());
        wait_playback_done();
        set_dims(32'd2, 32'd3);
        finish_matrix();
        wait_playback_done();
    endtask

    // random sizes and contents, some mid-load resizes, back-to-back matrices
    task automatic test_random_matrices(input int pct, input int budget);
        int first_load;
        int total;
        int part;
        first_load = loads_accepted;
        idle_pct   = pct;
        while (loads_accepted - first_load < budget) begin
            set_dims(pick_dim_word(), pick_dim_word());
            total = clamp_dim(rows_reg) * clamp_dim(cols_reg);
            if ($urandom_range(9) == 0 && total > 1) begin
                part = $urandom_range(1, total - 1);
                repeat (part) send_element(rand_element());
                wait_playback_done();
                set_dims(pick_dim_word(), pick_dim_word());
            end
            // further matrices of the same size follow back to back, each load waiting while busy is high
            repeat ($urandom_range(1, 3)) finish_matrix();
            wait_playback_done();
        end
        idle_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_element_value <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        fill_count = '0;
        rows_reg   = somr_pkg::DIM_RESET;
        cols_reg   = somr_pkg::DIM_RESET;
        foreach (matrix_store[i]) matrix_store[i] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_single_element();
        test_zero_dimension();
        test_strips();
        test_oversize_resize();

        // idling phases: none, heavy, moderate, none again
        test_random_matrices(0, 100);
        test_random_matrices(86, 100);
        test_random_matrices(32, 100);
        test_random_matrices(0, 100);

        wait_playback_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d element loads, %0d spiral words over %0d matrices",
                 loads_accepted, words_checked, matrices_played);
        $display("sizes 1x1 to 8x8, zero and oversized counts, mid-load resizes, sender gaps");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(5_000_000);
        $display("timeout with %0d words still pending", spiral_expect_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/somr_pkg.sv
rtl/somr_ram.sv
rtl/spiral_order_matrix_reader_core.sv
verif/spiral_order_matrix_reader_core_tb.sv
